// ===== rtl/core/b2da_pkg.sv =====
package b2da_pkg;

	// Default width of the word that is converted.
	localparam int VALUE_WIDTH_DEF = 32;

	// ASCII codes used in the text.
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	// Conversion modes.
	localparam logic REQ_UNSIGNED = 1'b0;
	localparam logic REQ_SIGNED   = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] text_char;
		logic       last;
	} out_item_t;

endpackage

// ===== rtl/core/binary_to_decimal_ascii_unit.sv =====
// Channel  Direction  Payload            Transfer when
// in       input      in_item_t          in_valid && in_ready
// out      output     out_item_t         out_valid && out_ready
//
// An item is loaded, then converted by double dabble, one bit of the magnitude
// per cycle over all VALUE_WIDTH bits; leading zero digits are then skipped,
// one per cycle, and the characters emitted one per cycle while out is not stalled.
// The conversion loop is bit-serial and the output register holds one character.
// Reset is asynchronous, active low, and clears the state and the output valid.
// A stall on out holds the current character in the output register; the next
// item is taken as soon as the last character of the current one is registered.
module binary_to_decimal_ascii_unit #(
	parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  b2da_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output b2da_pkg::out_item_t out_data
);
	import b2da_pkg::*;

	// Decimal digits needed for VALUE_WIDTH bits: floor(W * log10(2)) + 1.
	localparam int NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int BCDW = 4 * NDIG;
	localparam int BW   = $clog2(VALUE_WIDTH);
	localparam int DW   = $clog2(NDIG + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]             state_q;
	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BCDW-1:0]        bcd_q;
	logic [BW-1:0]          bit_cnt_q;
	logic [DW-1:0]          dig_cnt_q;
	logic                   sign_pend_q;
	logic                   lead_q;
	logic                   out_valid_q;
	out_item_t              out_q;

	logic [63:0]            value_ext;
	logic [VALUE_WIDTH-1:0] value_w;
	logic                   is_neg;
	logic [BCDW-1:0]        bcd_adj;
	logic [3:0]             top_dig;
	logic                   slot_free;
	logic                   in_xfer;
	logic                   skip_zero;
	logic                   char_load;

	// The input field is 32 bits wide; widths above that see zeros on top,
	// and narrower widths simply drop the upper bits.
	assign value_ext = {32'd0, in_data.value};
	assign value_w   = value_ext[VALUE_WIDTH-1:0];
	assign is_neg    = (in_data.req_type == REQ_SIGNED) && value_w[VALUE_WIDTH-1];

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign top_dig   = bcd_q[BCDW-1 -: 4];

	// A leading zero digit is dropped without using the output; the minus
	// sign, when pending, always goes out first.
	assign skip_zero = lead_q && top_dig == 4'd0 && dig_cnt_q > DW'(1);
	assign char_load = (state_q == ST_EMIT) && slot_free && (sign_pend_q || !skip_zero);

	// Double dabble correction: every BCD digit of five or more gets three
	// added before the shift, so that the shift carries correctly in decimal.
	always_comb begin
		logic [3:0] d;
		d = 4'd0;
		for (int i = 0; i < NDIG; i++) begin
			d = bcd_q[4*i +: 4];
			bcd_adj[4*i +: 4] = (d >= 4'd5) ? (d + 4'd3) : d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bit_cnt_q   <= '0;
			dig_cnt_q   <= '0;
			sign_pend_q <= 1'b0;
			lead_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (char_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						sign_pend_q <= is_neg;
						bit_cnt_q   <= BW'(VALUE_WIDTH - 1);
						state_q     <= ST_CONV;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q - 1'b1;
					if (bit_cnt_q == '0) begin
						dig_cnt_q <= DW'(NDIG);
						lead_q    <= 1'b1;
						state_q   <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (sign_pend_q) begin
						// The minus sign goes out before any digit.
						if (slot_free) begin
							sign_pend_q <= 1'b0;
						end
					end else if (skip_zero) begin
						// Leading zeros are dropped without using the output.
						dig_cnt_q <= dig_cnt_q - 1'b1;
					end else if (slot_free) begin
						lead_q    <= 1'b0;
						dig_cnt_q <= dig_cnt_q - 1'b1;
						if (dig_cnt_q == DW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers carry no reset; they are loaded before use.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					// The magnitude is formed at full width, so the most
					// negative word yields its exact unsigned magnitude.
					mag_q <= is_neg ? (~value_w + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : value_w;
					bcd_q <= '0;
				end
			end
			ST_CONV: begin
				bcd_q <= {bcd_adj[BCDW-2:0], mag_q[VALUE_WIDTH-1]};
				mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
			end
			ST_EMIT: begin
				if (sign_pend_q) begin
					if (slot_free) begin
						out_q.text_char <= CHAR_MINUS;
						out_q.last      <= 1'b0;
					end
				end else if (skip_zero) begin
					bcd_q <= {bcd_q[BCDW-5:0], 4'd0};
				end else if (slot_free) begin
					out_q.text_char <= CHAR_ZERO + {4'd0, top_dig};
					out_q.last      <= (dig_cnt_q == DW'(1));
					bcd_q           <= {bcd_q[BCDW-5:0], 4'd0};
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/core/b2da_checker.sv =====
module b2da_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input b2da_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input b2da_pkg::out_item_t out_data
);
	import b2da_pkg::*;

	// A stalled character holds its value until the transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	// The converter works on one item at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after a transfer");

	// A minus sign is always followed by at least one digit.
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.text_char == CHAR_MINUS |-> !out_data.last)
		else $error("minus sign flagged as last");

	// Only digits and the minus sign appear in the text.
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.text_char >= CHAR_ZERO
			&& out_data.text_char <= CHAR_ZERO + 8'd9)
			|| out_data.text_char == CHAR_MINUS)
		else $error("character outside the decimal text set");

	// Nothing is emitted in the cycle right after an item is taken.
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("output appeared before conversion");

endmodule

bind binary_to_decimal_ascii_unit b2da_checker u_b2da_checker (.*);
